### rtl/modexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
package modexp_pkg;

   localparam int BASE_W            = 32;
   localparam int EXP_IN_W          = 32;
   localparam int RES_W             = 30;
   localparam int PROD_W            = 60;
   localparam int DEFAULT_EXP_WIDTH = 32;

   localparam logic [RES_W-1:0] PRIME_MOD   = 30'd1000000007;
   localparam logic [31:0]      PRIME_X1    = 32'd1000000007;
   localparam logic [31:0]      PRIME_X2    = 32'd2000000014;
   localparam logic [30:0]      BARRETT_MU  = 31'd1152921496;
   localparam logic [RES_W-1:0] RES_ONE     = 30'd1;

   typedef enum logic {
      DEST_BASE = 1'b0,
      DEST_ACC  = 1'b1
   } dest_type;

   typedef struct packed {
      logic                valid;
      dest_type            dest;
      logic [BASE_W-1:0]   a;
      logic [RES_W-1:0]    b;
   } mm_op_type;

   typedef struct packed {
      logic                valid;
      dest_type            dest;
      logic [RES_W-1:0]    value;
   } mm_res_type;

endpackage

### rtl/modexp_mulmod.sv
// Pipelined modular multiplier with Barrett reduction by the fixed prime.
module modexp_mulmod
   import modexp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  mm_op_type  op,
   output mm_res_type res
);

   logic [61:0]        prod_full;
   logic [61:0]        quot_full;
   logic [60:0]        qp_full;
   logic [31:0]        r0;
   logic [31:0]        r1;
   logic [31:0]        r2;
   logic [31:0]        rsel;

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   dest_type           d1_ff, d2_ff, d3_ff, d4_ff;
   logic [PROD_W-1:0]  x1_ff, x1_in;
   logic [30:0]        q2_ff, q2_in;
   logic [31:0]        xlo2_ff, xlo3_ff;
   logic [31:0]        qp3_ff, qp3_in;
   logic [RES_W-1:0]   res4_ff, res4_in;

   assign prod_full = 62'(op.a) * 62'(op.b);
   assign x1_in     = prod_full[PROD_W-1:0];

   assign quot_full = 62'(x1_ff[59:29]) * 62'(BARRETT_MU);
   assign q2_in     = quot_full[61:31];

   assign qp_full   = 61'(q2_ff) * 61'(PRIME_MOD);
   assign qp3_in    = qp_full[31:0];

   always_comb begin
      r0 = xlo3_ff - qp3_ff;
      r1 = r0 - PRIME_X1;
      r2 = r0 - PRIME_X2;
      priority if (r0 >= PRIME_X2) begin
         rsel = r2;
      end else if (r0 >= PRIME_X1) begin
         rsel = r1;
      end else begin
         rsel = r0;
      end
      res4_in = rsel[RES_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= op.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff   <= op.dest;
      x1_ff   <= x1_in;
      d2_ff   <= d1_ff;
      q2_ff   <= q2_in;
      xlo2_ff <= x1_ff[31:0];
      d3_ff   <= d2_ff;
      qp3_ff  <= qp3_in;
      xlo3_ff <= xlo2_ff;
      d4_ff   <= d3_ff;
      res4_ff <= res4_in;
   end

   assign res.valid = v4_ff;
   assign res.dest  = d4_ff;
   assign res.value = res4_ff;

`ifndef NO_ASSERTIONS
   a_latency: assert property (@(posedge clock) disable iff (reset)
      op.valid |-> ##4 res.valid)
      else $error("Multiplier result did not appear four cycles after issue.");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (res.value < PRIME_MOD))
      else $error("Multiplier result is not fully reduced.");

   a_dest_kept: assert property (@(posedge clock) disable iff (reset)
      op.valid |-> ##4 (res.dest == $past(op.dest, 4)))
      else $error("Multiplier result lost its destination.");
`endif

endmodule

### rtl/modexp_ctrl.sv
// Sequencer that scans the exponent and issues squares and multiplies to the shared unit.
module modexp_ctrl
   import modexp_pkg::*;
#(
   parameter int EXP_WIDTH = DEFAULT_EXP_WIDTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BASE_W-1:0]    req_base_value,
   input  logic [EXP_IN_W-1:0]  req_exponent,
   input  logic                 out_free,
   output logic                 done_valid,
   output logic [RES_W-1:0]     done_value,
   output mm_op_type            op,
   input  mm_res_type           res
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SQR,
      ST_WAIT,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [RES_W-1:0]       acc_ff, acc_in;
   logic [RES_W-1:0]       b_ff, b_in;
   logic [EXP_WIDTH-1:0]   exp_ff, exp_in;
   logic [1:0]             pend_ff, pend_in;
   mm_op_type              op_ff, op_in;
   logic [63:0]            exp_wide;

   assign exp_wide = {32'd0, req_exponent};

   always_comb begin
      state_in = state_ff;
      acc_in   = acc_ff;
      b_in     = b_ff;
      exp_in   = exp_ff;
      op_in    = op_ff;
      op_in.valid = 1'b0;

      if (res.valid) begin
         if (res.dest == DEST_ACC) begin
            acc_in = res.value;
         end else begin
            b_in = res.value;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in.valid = 1'b1;
               op_in.dest  = DEST_BASE;
               op_in.a     = req_base_value;
               op_in.b     = RES_ONE;
               acc_in      = RES_ONE;
               exp_in      = exp_wide[EXP_WIDTH-1:0];
               state_in    = ST_WAIT;
            end
         end
         ST_MUL: begin
            if (exp_ff[0]) begin
               op_in.valid = 1'b1;
               op_in.dest  = DEST_ACC;
               op_in.a     = {2'b00, acc_ff};
               op_in.b     = b_ff;
            end
            state_in = ST_SQR;
         end
         ST_SQR: begin
            if ((exp_ff >> 1) != '0) begin
               op_in.valid = 1'b1;
               op_in.dest  = DEST_BASE;
               op_in.a     = {2'b00, b_ff};
               op_in.b     = b_ff;
            end
            exp_in   = exp_ff >> 1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (pend_ff == 2'(res.valid)) begin
               if (exp_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      pend_in = pend_ff + 2'(op_in.valid) - 2'(res.valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_ff     <= 2'd0;
         op_ff.valid <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_ff     <= pend_in;
         op_ff.valid <= op_in.valid;
      end
      acc_ff     <= acc_in;
      b_ff       <= b_in;
      exp_ff     <= exp_in;
      op_ff.dest <= op_in.dest;
      op_ff.a    <= op_in.a;
      op_ff.b    <= op_in.b;
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign done_valid = (state_ff == ST_DONE);
   assign done_value = acc_ff;
   assign op         = op_ff;

`ifndef NO_ASSERTIONS
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff <= 2'd2)
      else $error("More than two products outstanding.");

   a_no_stray_result: assert property (@(posedge clock) disable iff (reset)
      res.valid |-> (pend_ff != 2'd0))
      else $error("Product returned with nothing outstanding.");

   a_done_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE) |-> (pend_ff == 2'd0 && !res.valid && !op_ff.valid))
      else $error("Result offered while products are still in flight.");

   a_issue_state: assert property (@(posedge clock) disable iff (reset)
      op_ff.valid |-> ($past(state_ff) != ST_WAIT && $past(state_ff) != ST_DONE))
      else $error("Product issued from a waiting state.");
`endif

endmodule

### rtl/modular_exponentiation_top.sv
// A new item is accepted only in the idle state, after the previous result has entered the result
// register; each exponent bit waits for the four-stage shared modular multiplier, whose square
// must return before the next bit.
// Reset is synchronous and active high; it empties the sequencer, multiplier and result register.
module modular_exponentiation_top
   import modexp_pkg::*;
#(
   parameter int EXP_WIDTH = DEFAULT_EXP_WIDTH
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BASE_W-1:0]    req_base_value,
   input  logic [EXP_IN_W-1:0]  req_exponent,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RES_W-1:0]     rsp_residue
);

   mm_op_type          op;
   mm_res_type         res;
   logic               out_free;
   logic               done_valid;
   logic [RES_W-1:0]   done_value;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]   rsp_residue_ff, rsp_residue_in;

   modexp_ctrl #(
      .EXP_WIDTH (EXP_WIDTH)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_base_value (req_base_value),
      .req_exponent   (req_exponent),
      .out_free       (out_free),
      .done_valid     (done_valid),
      .done_value     (done_value),
      .op             (op),
      .res            (res)
   );

   modexp_mulmod u_mulmod (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .res   (res)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_residue_in = rsp_residue_ff;
      if (done_valid && out_free) begin
         rsp_valid_in   = 1'b1;
         rsp_residue_in = done_value;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_residue_ff <= rsp_residue_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_residue = rsp_residue_ff;

endmodule
